FILE: hw/rtl/utf8_unicode_whitespace_trimmer_defines.svh
// ----------------------------------------------------------------------------
// utf8 whitespace trimmer assertion macros
// shared property forms for the trimmer rtl
// ----------------------------------------------------------------------------
`ifndef UTF8_UNICODE_WHITESPACE_TRIMMER_DEFINES_SVH
`define UTF8_UNICODE_WHITESPACE_TRIMMER_DEFINES_SVH

// condition must hold at every clock edge out of reset
`define UWSTRIM_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// consequence must hold in the cycle after the antecedent
`define UWSTRIM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/uwstrim_pkg.sv
// ----------------------------------------------------------------------------
// uwstrim_pkg
// types, constants and helpers shared by the whitespace trimmer modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package uwstrim_pkg;

	localparam int unsigned MAX_BYTES_DEF = 512;
	localparam int unsigned SPAN_W        = 10;
	localparam int unsigned CP_W          = 21;

	localparam logic [7:0] ASCII_LIMIT = 8'h80;
	localparam logic [7:0] LEAD_MIN    = 8'hC2;
	localparam logic [7:0] LEAD_MAX    = 8'hF4;
	localparam logic [7:0] LEAD3_MIN   = 8'hE0;
	localparam logic [7:0] LEAD4_MIN   = 8'hF0;
	localparam logic [7:0] CONT_MASK   = 8'hC0;
	localparam logic [7:0] CONT_TAG    = 8'h80;

	localparam logic [CP_W-1:0] CP_TAB     = 21'h00009;
	localparam logic [CP_W-1:0] CP_CR      = 21'h0000D;
	localparam logic [CP_W-1:0] CP_SPACE   = 21'h00020;
	localparam logic [CP_W-1:0] CP_NEL     = 21'h00085;
	localparam logic [CP_W-1:0] CP_NBSP    = 21'h000A0;
	localparam logic [CP_W-1:0] CP_OGHAM   = 21'h01680;
	localparam logic [CP_W-1:0] CP_ENQ     = 21'h02000;
	localparam logic [CP_W-1:0] CP_HAIR    = 21'h0200A;
	localparam logic [CP_W-1:0] CP_LSEP    = 21'h02028;
	localparam logic [CP_W-1:0] CP_PSEP    = 21'h02029;
	localparam logic [CP_W-1:0] CP_NNBSP   = 21'h0202F;
	localparam logic [CP_W-1:0] CP_MMSP    = 21'h0205F;
	localparam logic [CP_W-1:0] CP_IDEOSP  = 21'h03000;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       is_final;
	} text_item_t;

	typedef struct packed {
		logic [SPAN_W-1:0] span_start;
		logic [SPAN_W-1:0] span_length;
		logic [SPAN_W-1:0] span_points;
		logic              too_long;
	} span_item_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_F_CHK,
		ST_F_LEAD,
		ST_F_NEXT,
		ST_F_CONT,
		ST_F_EVAL,
		ST_B_CHK,
		ST_B_RD,
		ST_B_USE,
		ST_B_EVAL,
		ST_C_CHK,
		ST_C_USE,
		ST_EMIT
	} state_t;

	typedef enum logic [2:0] {
		ACC_HOLD,
		ACC_CLEAR,
		ACC_LEAD_FWD,
		ACC_CONT_FWD,
		ACC_LEAD_BACK,
		ACC_CONT_BACK
	} acc_op_t;

	typedef struct packed {
		acc_op_t    op;
		logic [1:0] shift;
	} acc_ctl_t;

	typedef struct packed {
		logic       cont;
		logic [2:0] width;
		logic       blank;
	} acc_stat_t;

	function automatic logic is_blank(input logic [CP_W-1:0] cp);
		is_blank = (cp >= CP_TAB && cp <= CP_CR) || cp == CP_SPACE || cp == CP_NEL ||
			cp == CP_NBSP || cp == CP_OGHAM || (cp >= CP_ENQ && cp <= CP_HAIR) ||
			cp == CP_LSEP || cp == CP_PSEP || cp == CP_NNBSP || cp == CP_MMSP ||
			cp == CP_IDEOSP;
	endfunction

endpackage

FILE: hw/rtl/uwstrim_buf.sv
// ----------------------------------------------------------------------------
// uwstrim_buf
// string byte buffer, one write port and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uwstrim_buf #(
	parameter int unsigned DEPTH = uwstrim_pkg::MAX_BYTES_DEF,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/uwstrim_acc.sv
// ----------------------------------------------------------------------------
// uwstrim_acc
// shared byte classifier and code point accumulator used by both scans
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uwstrim_acc (
	input  logic                  clk,
	input  uwstrim_pkg::acc_ctl_t ctl,
	input  logic [7:0]            data,
	output uwstrim_pkg::acc_stat_t stat
);

	localparam int unsigned CPW = uwstrim_pkg::CP_W;

	logic [CPW-1:0] cp_q;
	logic [2:0]     width;
	logic [CPW-1:0] lead_bits;
	logic [CPW-1:0] cont_bits;
	logic [CPW-1:0] lead_shl;
	logic [CPW-1:0] cont_shl;

	// lead byte decode: 0 width means malformed
	always_comb begin
		if (data < uwstrim_pkg::ASCII_LIMIT) begin
			width = 3'd1;
		end else if (data >= uwstrim_pkg::LEAD_MIN && data <= uwstrim_pkg::LEAD_MAX) begin
			if (data < uwstrim_pkg::LEAD3_MIN) begin
				width = 3'd2;
			end else if (data < uwstrim_pkg::LEAD4_MIN) begin
				width = 3'd3;
			end else begin
				width = 3'd4;
			end
		end else begin
			width = 3'd0;
		end
	end

	always_comb begin
		case (width)
			3'd1:    lead_bits = CPW'(data[6:0]);
			3'd2:    lead_bits = CPW'(data[4:0]);
			3'd3:    lead_bits = CPW'(data[3:0]);
			3'd4:    lead_bits = CPW'(data[2:0]);
			default: lead_bits = '0;
		endcase
		cont_bits = CPW'(data[5:0]);
	end

	// backward assembly places each payload six bits further up
	always_comb begin
		case (ctl.shift)
			2'd0:    begin lead_shl = lead_bits;         cont_shl = cont_bits;         end
			2'd1:    begin lead_shl = lead_bits << 6;    cont_shl = cont_bits << 6;    end
			2'd2:    begin lead_shl = lead_bits << 12;   cont_shl = cont_bits << 12;   end
			default: begin lead_shl = lead_bits << 18;   cont_shl = cont_bits << 18;   end
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			uwstrim_pkg::ACC_HOLD:      cp_q <= cp_q;
			uwstrim_pkg::ACC_CLEAR:     cp_q <= '0;
			uwstrim_pkg::ACC_LEAD_FWD:  cp_q <= lead_bits;
			uwstrim_pkg::ACC_CONT_FWD:  cp_q <= {cp_q[CPW-7:0], data[5:0]};
			uwstrim_pkg::ACC_LEAD_BACK: cp_q <= cp_q | lead_shl;
			uwstrim_pkg::ACC_CONT_BACK: cp_q <= cp_q | cont_shl;
			default:                    cp_q <= cp_q;
		endcase
	end

	assign stat.cont  = (data & uwstrim_pkg::CONT_MASK) == uwstrim_pkg::CONT_TAG;
	assign stat.width = width;
	assign stat.blank = uwstrim_pkg::is_blank(cp_q);

endmodule

FILE: hw/rtl/uwstrim_seq.sv
// ----------------------------------------------------------------------------
// uwstrim_seq
// load, forward scan, backward scan and point count sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "utf8_unicode_whitespace_trimmer_defines.svh"

module uwstrim_seq #(
	parameter int unsigned MAX_BYTES = uwstrim_pkg::MAX_BYTES_DEF,
	parameter int unsigned AW        = $clog2(MAX_BYTES),
	parameter int unsigned CW        = $clog2(MAX_BYTES + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    text_valid,
	output logic                    text_ready,
	input  uwstrim_pkg::text_item_t text,
	output logic                    buf_we,
	output logic [AW-1:0]           buf_waddr,
	output logic [AW-1:0]           buf_raddr,
	output uwstrim_pkg::acc_ctl_t   acc_ctl,
	input  uwstrim_pkg::acc_stat_t  acc_stat,
	input  logic                    slot_free,
	output logic                    emit,
	output uwstrim_pkg::span_item_t result
);

	localparam int unsigned SW = uwstrim_pkg::SPAN_W;
	localparam logic [CW-1:0] FULL = CW'(MAX_BYTES);

	uwstrim_pkg::state_t state_q, state_d;

	logic [CW-1:0] fill_q;
	logic          ovf_q;
	logic [CW-1:0] len_q;
	logic [CW-1:0] front_q;
	logic [CW-1:0] back_q;
	logic [CW-1:0] pos_q;
	logic [CW-1:0] cnt_q;
	logic [1:0]    rem_q;
	logic [1:0]    ncont_q;
	logic          too_long_q;

	logic          text_acc;
	logic          has_room;
	logic [CW-1:0] load_len;
	logic          load_ovf;
	logic          fwd_over;
	logic          backing;
	logic          lead_ok;

	assign text_acc  = text_valid && text_ready;
	assign has_room  = fill_q != FULL;
	assign load_len  = has_room ? fill_q + CW'(1) : fill_q;
	assign load_ovf  = ovf_q || !has_room;
	assign fwd_over  = ({1'b0, pos_q} + (CW+1)'(acc_stat.width)) > {1'b0, len_q};
	assign backing   = (pos_q > front_q) && acc_stat.cont && (ncont_q != 2'd3);
	assign lead_ok   = acc_stat.width == ({1'b0, ncont_q} + 3'd1);

	assign buf_we    = text_acc && has_room;
	assign buf_waddr = fill_q[AW-1:0];
	assign buf_raddr = pos_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= uwstrim_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		text_ready    = 1'b0;
		emit          = 1'b0;
		acc_ctl.op    = uwstrim_pkg::ACC_HOLD;
		acc_ctl.shift = ncont_q;
		unique case (state_q)
			uwstrim_pkg::ST_LOAD: begin
				text_ready = 1'b1;
				if (text_acc && text.is_final) begin
					state_d = load_ovf ? uwstrim_pkg::ST_EMIT : uwstrim_pkg::ST_F_CHK;
				end
			end
			uwstrim_pkg::ST_F_CHK: begin
				state_d = (pos_q == len_q) ? uwstrim_pkg::ST_B_CHK : uwstrim_pkg::ST_F_LEAD;
			end
			uwstrim_pkg::ST_F_LEAD: begin
				acc_ctl.op = uwstrim_pkg::ACC_LEAD_FWD;
				if (acc_stat.width == 3'd0 || fwd_over) begin
					state_d = uwstrim_pkg::ST_B_CHK;
				end else begin
					state_d = uwstrim_pkg::ST_F_NEXT;
				end
			end
			uwstrim_pkg::ST_F_NEXT: begin
				state_d = (rem_q == 2'd0) ? uwstrim_pkg::ST_F_EVAL : uwstrim_pkg::ST_F_CONT;
			end
			uwstrim_pkg::ST_F_CONT: begin
				if (acc_stat.cont) begin
					acc_ctl.op = uwstrim_pkg::ACC_CONT_FWD;
					state_d    = uwstrim_pkg::ST_F_NEXT;
				end else begin
					state_d = uwstrim_pkg::ST_B_CHK;
				end
			end
			uwstrim_pkg::ST_F_EVAL: begin
				state_d = acc_stat.blank ? uwstrim_pkg::ST_F_CHK : uwstrim_pkg::ST_B_CHK;
			end
			uwstrim_pkg::ST_B_CHK: begin
				acc_ctl.op = uwstrim_pkg::ACC_CLEAR;
				state_d    = (back_q == front_q) ? uwstrim_pkg::ST_C_CHK : uwstrim_pkg::ST_B_RD;
			end
			uwstrim_pkg::ST_B_RD: begin
				state_d = uwstrim_pkg::ST_B_USE;
			end
			uwstrim_pkg::ST_B_USE: begin
				if (backing) begin
					acc_ctl.op = uwstrim_pkg::ACC_CONT_BACK;
					state_d    = uwstrim_pkg::ST_B_RD;
				end else begin
					acc_ctl.op = uwstrim_pkg::ACC_LEAD_BACK;
					state_d    = lead_ok ? uwstrim_pkg::ST_B_EVAL : uwstrim_pkg::ST_C_CHK;
				end
			end
			uwstrim_pkg::ST_B_EVAL: begin
				state_d = acc_stat.blank ? uwstrim_pkg::ST_B_CHK : uwstrim_pkg::ST_C_CHK;
			end
			uwstrim_pkg::ST_C_CHK: begin
				state_d = (pos_q == back_q) ? uwstrim_pkg::ST_EMIT : uwstrim_pkg::ST_C_USE;
			end
			uwstrim_pkg::ST_C_USE: begin
				state_d = uwstrim_pkg::ST_C_CHK;
			end
			uwstrim_pkg::ST_EMIT: begin
				if (slot_free) begin
					emit    = 1'b1;
					state_d = uwstrim_pkg::ST_LOAD;
				end
			end
			default: begin
				state_d = uwstrim_pkg::ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			ovf_q   <= 1'b0;
			len_q   <= '0;
			front_q <= '0;
			back_q  <= '0;
			pos_q   <= '0;
		end else begin
			unique case (state_q)
				uwstrim_pkg::ST_LOAD: begin
					if (text_acc) begin
						if (text.is_final) begin
							len_q   <= load_len;
							back_q  <= load_len;
							front_q <= '0;
							pos_q   <= '0;
							fill_q  <= '0;
							ovf_q   <= 1'b0;
						end else begin
							fill_q <= load_len;
							ovf_q  <= load_ovf;
						end
					end
				end
				uwstrim_pkg::ST_F_LEAD: begin
					pos_q <= pos_q + CW'(1);
				end
				uwstrim_pkg::ST_F_CONT: begin
					if (acc_stat.cont) begin
						pos_q <= pos_q + CW'(1);
					end
				end
				uwstrim_pkg::ST_F_EVAL: begin
					if (acc_stat.blank) begin
						front_q <= pos_q;
					end
				end
				uwstrim_pkg::ST_B_CHK: begin
					pos_q <= (back_q == front_q) ? front_q : back_q - CW'(1);
				end
				uwstrim_pkg::ST_B_USE: begin
					if (backing) begin
						pos_q <= pos_q - CW'(1);
					end else if (!lead_ok) begin
						pos_q <= front_q;
					end
				end
				uwstrim_pkg::ST_B_EVAL: begin
					if (acc_stat.blank) begin
						back_q <= pos_q;
					end else begin
						pos_q <= front_q;
					end
				end
				uwstrim_pkg::ST_C_USE: begin
					pos_q <= pos_q + CW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// scan payload, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			uwstrim_pkg::ST_LOAD: begin
				if (text_acc && text.is_final) begin
					too_long_q <= load_ovf;
				end
			end
			uwstrim_pkg::ST_F_LEAD: begin
				rem_q <= 2'(acc_stat.width - 3'd1);
			end
			uwstrim_pkg::ST_F_CONT: begin
				rem_q <= rem_q - 2'd1;
			end
			uwstrim_pkg::ST_B_CHK: begin
				ncont_q <= 2'd0;
				cnt_q   <= '0;
			end
			uwstrim_pkg::ST_B_USE: begin
				if (backing) begin
					ncont_q <= ncont_q + 2'd1;
				end
			end
			uwstrim_pkg::ST_C_USE: begin
				if (!acc_stat.cont) begin
					cnt_q <= cnt_q + CW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		if (too_long_q) begin
			result.span_start  = '0;
			result.span_length = '0;
			result.span_points = '0;
			result.too_long    = 1'b1;
		end else begin
			result.span_start  = SW'(front_q);
			result.span_length = SW'(back_q - front_q);
			result.span_points = SW'(cnt_q);
			result.too_long    = 1'b0;
		end
	end

	`UWSTRIM_ASSERT_ALWAYS(a_front_le_back, front_q <= back_q, "front pointer passed back pointer")
	`UWSTRIM_ASSERT_ALWAYS(a_back_le_len, back_q <= len_q, "back pointer beyond string length")
	`UWSTRIM_ASSERT_ALWAYS(a_pos_le_len, pos_q <= len_q, "scan pointer beyond string length")
	`UWSTRIM_ASSERT_NEXT(a_emit_reload, emit, state_q == uwstrim_pkg::ST_LOAD && fill_q == '0, "no clean reload after result")

endmodule

FILE: hw/rtl/utf8_unicode_whitespace_trimmer.sv
// sequence: one byte per cycle while loading; after the final byte the forward scan and then
//   the backward scan read bytes and test each code point, the point count walks the kept
//   bytes, and the emit state then moves the result into the output register
// throughput: one string at a time; the input is held off from the final byte until the
//   result moves into the output register
// reset: sequencer returns to loading with empty fill count; buffer contents are not cleared
// ----------------------------------------------------------------------------
// utf8_unicode_whitespace_trimmer
// buffers a utf-8 string and reports the span left after trimming white space
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_unicode_whitespace_trimmer #(
	parameter int unsigned MAX_BYTES = uwstrim_pkg::MAX_BYTES_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    text_valid,
	output logic                    text_ready,
	input  uwstrim_pkg::text_item_t text,
	output logic                    span_valid,
	input  logic                    span_ready,
	output uwstrim_pkg::span_item_t span
);

	localparam int unsigned AW = $clog2(MAX_BYTES);
	localparam int unsigned CW = $clog2(MAX_BYTES + 1);

	logic                    buf_we;
	logic [AW-1:0]           buf_waddr;
	logic [AW-1:0]           buf_raddr;
	logic [7:0]              buf_rdata;
	uwstrim_pkg::acc_ctl_t   acc_ctl;
	uwstrim_pkg::acc_stat_t  acc_stat;
	logic                    emit;
	uwstrim_pkg::span_item_t result;
	logic                    span_valid_q;
	uwstrim_pkg::span_item_t span_q;
	logic                    slot_free;

	assign slot_free = !span_valid_q || span_ready;

	uwstrim_buf #(
		.DEPTH (MAX_BYTES),
		.AW    (AW)
	) u_buf (
		.clk   (clk),
		.we    (buf_we),
		.waddr (buf_waddr),
		.wdata (text.text_byte),
		.raddr (buf_raddr),
		.rdata (buf_rdata)
	);

	uwstrim_acc u_acc (
		.clk  (clk),
		.ctl  (acc_ctl),
		.data (buf_rdata),
		.stat (acc_stat)
	);

	uwstrim_seq #(
		.MAX_BYTES (MAX_BYTES),
		.AW        (AW),
		.CW        (CW)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text_ready (text_ready),
		.text       (text),
		.buf_we     (buf_we),
		.buf_waddr  (buf_waddr),
		.buf_raddr  (buf_raddr),
		.acc_ctl    (acc_ctl),
		.acc_stat   (acc_stat),
		.slot_free  (slot_free),
		.emit       (emit),
		.result     (result)
	);

	// output register decouples the result from the next string's load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_valid_q <= 1'b0;
		end else if (emit) begin
			span_valid_q <= 1'b1;
		end else if (span_ready) begin
			span_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			span_q <= result;
		end
	end

	assign span_valid = span_valid_q;
	assign span       = span_q;

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// feeds utf-8 strings byte by byte into the whitespace trimmer under random
// gaps and stalls, and checks each span against a local prediction of the trim
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	localparam int unsigned STORE_BYTES  = uwstrim_pkg::MAX_BYTES_DEF;
	localparam int unsigned SPAN_BITS    = uwstrim_pkg::SPAN_W;
	localparam int unsigned RANDOM_BYTES = 200;
	localparam int unsigned CALM_BYTES   = 120;
	localparam int unsigned HOLD_AT_SPAN = 12;
	localparam int unsigned LONG_HOLD    = 300;
	localparam int unsigned TAIL_CYCLES  = 200;
	// long enough to cover the scan of a full buffer of blanks
	localparam int unsigned STALL_LIMIT  = 20000;

	typedef bit [7:0] octet_q_t [$];

	typedef struct {
		uwstrim_pkg::text_item_t item;
		bit                      drain_first;
	} feed_t;

	typedef enum {
		TOK_WHITE,
		TOK_OVERLONG,
		TOK_PLAIN,
		TOK_WIDE,
		TOK_NEAR,
		TOK_NOISE,
		TOK_BROKEN
	} token_kind_t;

	logic                    clk        = 1'b0;
	logic                    arst_n     = 1'b0;
	logic                    text_valid = 1'b0;
	logic                    span_ready = 1'b0;
	uwstrim_pkg::text_item_t text       = '0;
	logic                    text_ready;
	logic                    span_valid;
	uwstrim_pkg::span_item_t span;

	feed_t                   byte_feed [$];
	uwstrim_pkg::span_item_t spans_due [$];
	bit [7:0]                text_buf [STORE_BYTES];
	int unsigned             text_fill;
	bit                      text_overrun;
	int unsigned             send_gap;
	int unsigned             stall_left;
	int unsigned             finals_sent;
	int unsigned             spans_taken;
	int unsigned             mismatches;
	bit                      calm;
	bit                      hold_done;
	uwstrim_pkg::span_item_t want;

	utf8_unicode_whitespace_trimmer u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text_ready (text_ready),
		.text       (text),
		.span_valid (span_valid),
		.span_ready (span_ready),
		.span       (span)
	);

	always #5 clk = ~clk;

	function automatic bit is_cont_byte(bit [7:0] b);
		return (b & uwstrim_pkg::CONT_MASK) == uwstrim_pkg::CONT_TAG;
	endfunction

	function automatic bit is_white(int unsigned cp);
		return cp inside {[uwstrim_pkg::CP_TAB:uwstrim_pkg::CP_CR], uwstrim_pkg::CP_SPACE,
			uwstrim_pkg::CP_NEL, uwstrim_pkg::CP_NBSP, uwstrim_pkg::CP_OGHAM,
			[uwstrim_pkg::CP_ENQ:uwstrim_pkg::CP_HAIR], uwstrim_pkg::CP_LSEP,
			uwstrim_pkg::CP_PSEP, uwstrim_pkg::CP_NNBSP, uwstrim_pkg::CP_MMSP,
			uwstrim_pkg::CP_IDEOSP};
	endfunction

	// width of the sequence at pos, 0 when malformed or cut off by the end
	function automatic int unsigned seq_width(int unsigned pos, int unsigned len,
			output int unsigned cp);
		bit [7:0]    lead;
		int unsigned w;
		int unsigned k;
		cp = 0;
		if (pos >= len)
			return 0;
		lead = text_buf[pos];
		if (lead < uwstrim_pkg::ASCII_LIMIT) begin
			cp = lead;
			return 1;
		end
		if (lead < uwstrim_pkg::LEAD_MIN || lead > uwstrim_pkg::LEAD_MAX)
			return 0;
		w = lead < uwstrim_pkg::LEAD3_MIN ? 2 : (lead < uwstrim_pkg::LEAD4_MIN ? 3 : 4);
		if (pos + w > len)
			return 0;
		cp = lead & (w == 2 ? 8'h1F : (w == 3 ? 8'h0F : 8'h07));
		for (k = 1; k < w; k++) begin
			if (!is_cont_byte(text_buf[pos + k])) begin
				cp = 0;
				return 0;
			end
			cp = (cp << 6) | (text_buf[pos + k] & 8'h3F);
		end
		return w;
	endfunction

	function automatic uwstrim_pkg::span_item_t trim_span();
		uwstrim_pkg::span_item_t r;
		int unsigned             head;
		int unsigned             tail;
		int unsigned             s;
		int unsigned             cp;
		int unsigned             w;
		int unsigned             pts;
		int unsigned             i;
		r = '0;
		if (text_overrun) begin
			r.too_long = 1'b1;
			return r;
		end
		head = 0;
		while (head < text_fill) begin
			w = seq_width(head, text_fill, cp);
			if (w == 0 || !is_white(cp))
				break;
			head += w;
		end
		tail = text_fill;
		while (tail > head) begin
			s = tail - 1;
			// back over at most three continuation bytes to find the lead
			while (s > head && is_cont_byte(text_buf[s]) && tail - s < 4)
				s--;
			w = seq_width(s, text_fill, cp);
			if (w != tail - s || !is_white(cp))
				break;
			tail = s;
		end
		pts = 0;
		for (i = head; i < tail; i++)
			if (!is_cont_byte(text_buf[i]))
				pts++;
		r.span_start  = SPAN_BITS'(head);
		r.span_length = SPAN_BITS'(tail - head);
		r.span_points = SPAN_BITS'(pts);
		return r;
	endfunction

	task automatic check_field(input string name, input logic [SPAN_BITS-1:0] want_v,
			input logic [SPAN_BITS-1:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			mismatches++;
		end
	endtask

	task automatic put_cp(ref octet_q_t s, input int unsigned cp);
		if (cp < 'h80) begin
			s.push_back(cp[7:0]);
		end else if (cp < 'h800) begin
			s.push_back(8'hC0 | cp[10:6]);
			s.push_back(8'h80 | cp[5:0]);
		end else if (cp < 'h10000) begin
			s.push_back(8'hE0 | cp[15:12]);
			s.push_back(8'h80 | cp[11:6]);
			s.push_back(8'h80 | cp[5:0]);
		end else begin
			s.push_back(8'hF0 | cp[20:18]);
			s.push_back(8'h80 | cp[17:12]);
			s.push_back(8'h80 | cp[11:6]);
			s.push_back(8'h80 | cp[5:0]);
		end
	endtask

	function automatic int unsigned white_cp(int unsigned k);
		if (k < 5)
			return uwstrim_pkg::CP_TAB + k;
		if (k < 16)
			return uwstrim_pkg::CP_ENQ + k - 5;
		case (k)
			16: return uwstrim_pkg::CP_SPACE;
			17: return uwstrim_pkg::CP_NEL;
			18: return uwstrim_pkg::CP_NBSP;
			19: return uwstrim_pkg::CP_OGHAM;
			20: return uwstrim_pkg::CP_LSEP;
			21: return uwstrim_pkg::CP_PSEP;
			22: return uwstrim_pkg::CP_NNBSP;
			23: return uwstrim_pkg::CP_MMSP;
			default: return uwstrim_pkg::CP_IDEOSP;
		endcase
	endfunction

	// code points just outside the blank set
	function automatic int unsigned near_cp(int unsigned k);
		case (k)
			0: return uwstrim_pkg::CP_TAB - 1;
			1: return uwstrim_pkg::CP_CR + 1;
			2: return uwstrim_pkg::CP_SPACE - 1;
			3: return uwstrim_pkg::CP_SPACE + 1;
			4: return uwstrim_pkg::CP_NEL - 1;
			5: return uwstrim_pkg::CP_NEL + 1;
			6: return uwstrim_pkg::CP_NBSP + 1;
			7: return uwstrim_pkg::CP_OGHAM + 1;
			8: return uwstrim_pkg::CP_ENQ - 1;
			9: return uwstrim_pkg::CP_HAIR + 1;
			10: return uwstrim_pkg::CP_LSEP - 1;
			11: return uwstrim_pkg::CP_PSEP + 1;
			12: return uwstrim_pkg::CP_MMSP + 1;
			default: return uwstrim_pkg::CP_IDEOSP + 1;
		endcase
	endfunction

	task automatic add_token(ref octet_q_t s, input token_kind_t kind);
		int unsigned cp;
		bit [7:0]    lead;
		int unsigned n;
		case (kind)
			TOK_WHITE: put_cp(s, white_cp($urandom_range(0, 24)));
			TOK_OVERLONG: begin
				// overlong forms still decode as blanks here
				if ($urandom_range(0, 1))
					s = {s, 8'hE0, 8'h80, 8'hA0};
				else
					s = {s, 8'hF0, 8'h80, 8'h82, 8'h85};
			end
			TOK_PLAIN: s.push_back(8'($urandom_range(8'h21, 8'h7E)));
			TOK_WIDE: begin
				case ($urandom_range(0, 2))
					0: cp = $urandom_range('h80, 'h7FF);
					1: cp = $urandom_range('h800, 'hFFFF);
					default: cp = $urandom_range('h10000, 'h10FFFF);
				endcase
				if (is_white(cp))
					cp = 'h4E2D;
				put_cp(s, cp);
			end
			TOK_NEAR: put_cp(s, near_cp($urandom_range(0, 13)));
			TOK_NOISE: s.push_back(8'($urandom_range(0, 255)));
			default: begin
				case ($urandom_range(0, 2))
					0: begin
						// lead byte short of its continuations
						lead = 8'($urandom_range(uwstrim_pkg::LEAD_MIN, uwstrim_pkg::LEAD_MAX));
						n = lead < uwstrim_pkg::LEAD3_MIN ? 2 :
							(lead < uwstrim_pkg::LEAD4_MIN ? 3 : 4);
						s.push_back(lead);
						repeat ($urandom_range(0, n - 2))
							s.push_back(8'h80 | 8'($urandom_range(0, 63)));
					end
					1: begin
						repeat ($urandom_range(1, 4))
							s.push_back(8'h80 | 8'($urandom_range(0, 63)));
					end
					default: begin
						n = $urandom_range(0, 12);
						s.push_back(n < 2 ? 8'(8'hC0 + n) : 8'(8'hF3 + n));
						s.push_back(8'hA0);
					end
				endcase
			end
		endcase
	endtask

	function automatic token_kind_t body_kind();
		case ($urandom_range(0, 10))
			0, 1, 2, 3: return TOK_PLAIN;
			4, 5, 6: return TOK_WIDE;
			7, 8: return TOK_NEAR;
			9: return TOK_WHITE;
			default: return TOK_BROKEN;
		endcase
	endfunction

	function automatic token_kind_t edge_kind();
		return $urandom_range(0, 5) == 0 ? TOK_OVERLONG : TOK_WHITE;
	endfunction

	function automatic token_kind_t junk_kind();
		case ($urandom_range(0, 3))
			0: return TOK_NOISE;
			1: return TOK_BROKEN;
			2: return TOK_WHITE;
			default: return TOK_NEAR;
		endcase
	endfunction

	task automatic build_random(ref octet_q_t s);
		int unsigned style;
		s.delete();
		style = $urandom_range(0, 9);
		if (style < 8) begin
			repeat ($urandom_range(0, 3))
				add_token(s, edge_kind());
			repeat (style == 0 ? $urandom_range(5, 30) : $urandom_range(0, 4))
				add_token(s, body_kind());
			repeat ($urandom_range(0, 3))
				add_token(s, edge_kind());
		end else begin
			repeat ($urandom_range(1, 10))
				add_token(s, junk_kind());
		end
		if (s.size() == 0)
			add_token(s, TOK_PLAIN);
	endtask

	task automatic push_string(input octet_q_t s, input bit drain_first);
		feed_t       f;
		int unsigned i;
		for (i = 0; i < s.size(); i++) begin
			f.item.text_byte = s[i];
			f.item.is_final  = (i == s.size() - 1);
			f.drain_first    = drain_first && i == 0;
			byte_feed.push_back(f);
		end
	endtask

	// sender: offers bytes, predicts the span on every final transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_valid <= 1'b0;
			text <= '0;
		end else begin
			if (text_valid && text_ready) begin
				if (text_fill < STORE_BYTES) begin
					text_buf[text_fill] = text.text_byte;
					text_fill++;
				end else begin
					text_overrun = 1'b1;
				end
				if (text.is_final) begin
					spans_due.push_back(trim_span());
					text_fill = 0;
					text_overrun = 1'b0;
					finals_sent++;
				end
				if (!calm && $urandom_range(0, 3) == 0)
					send_gap = $urandom_range(1, 6);
			end
			if (!text_valid || text_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					text_valid <= 1'b0;
				end else if (byte_feed.size() == 0 ||
						(byte_feed[0].drain_first && finals_sent != spans_taken)) begin
					text_valid <= 1'b0;
				end else begin
					text <= byte_feed[0].item;
					text_valid <= 1'b1;
					void'(byte_feed.pop_front());
				end
			end
		end
	end

	// receiver: checks each span transaction and applies back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_ready <= 1'b0;
		end else begin
			if (span_valid && span_ready) begin
				spans_taken <= spans_taken + 1;
				if (spans_due.size() == 0) begin
					$error("span transaction with nothing expected: %p", span);
					mismatches++;
				end else begin
					want = spans_due.pop_front();
					check_field("span_start", want.span_start, span.span_start);
					check_field("span_length", want.span_length, span.span_length);
					check_field("span_points", want.span_points, span.span_points);
					check_field("too_long", SPAN_BITS'(want.too_long),
						SPAN_BITS'(span.too_long));
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				span_ready <= 1'b0;
			end else if (!hold_done && spans_taken == HOLD_AT_SPAN) begin
				// long hold so the block backs up and stalls its input
				hold_done = 1'b1;
				stall_left = LONG_HOLD;
				span_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 5);
				span_ready <= 1'b0;
			end else begin
				span_ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (arst_n && !((text_valid && text_ready) || (span_valid && span_ready)))
				quiet++;
			else
				quiet = 0;
		end
		$display("utf8_unicode_whitespace_trimmer: mismatch");
		$finish;
	end

	initial begin : stimulus
		octet_q_t    s;
		int unsigned random_bytes;
		// extremes of the byte and a single blank
		push_string({8'h00}, 1'b0);
		push_string({8'hFF}, 1'b0);
		push_string({8'h20}, 1'b0);
		// ascii blanks at the range ends, trailing no-break space
		push_string({8'h09, 8'h0D, 8'h41, 8'hC2, 8'hA0}, 1'b0);
		// ideographic space ahead of a four-byte point, line separator behind
		push_string({8'hE3, 8'h80, 8'h80, 8'hF0, 8'h9F, 8'h98, 8'h80,
			8'hE2, 8'h80, 8'hA8}, 1'b0);
		// next line, stray continuation, truncated tail
		push_string({8'hC2, 8'h85, 8'h80, 8'h41, 8'hE2, 8'h80}, 1'b0);
		// run of continuations longer than the backward reach
		push_string({8'h41, 8'h80, 8'h80, 8'h80, 8'h80, 8'h20}, 1'b0);
		// one byte beyond the buffer, sent once every earlier span is back
		s.delete();
		repeat (STORE_BYTES + 1)
			add_token(s, TOK_NOISE);
		push_string(s, 1'b1);
		random_bytes = 0;
		while (random_bytes < RANDOM_BYTES) begin
			build_random(s);
			push_string(s, $urandom_range(0, 40) == 0);
			random_bytes += s.size();
		end

		repeat (12)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (byte_feed.size() >= CALM_BYTES)
			@(negedge clk);
		calm = 1'b1;
		while (byte_feed.size() != 0 || text_valid || spans_taken < finals_sent)
			@(negedge clk);
		repeat (TAIL_CYCLES)
			@(negedge clk);

		if (spans_due.size() != 0) begin
			$error("%0d spans expected but never delivered", spans_due.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("utf8_unicode_whitespace_trimmer: match");
		else
			$display("utf8_unicode_whitespace_trimmer: mismatch");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/uwstrim_pkg.sv
hw/rtl/uwstrim_buf.sv
hw/rtl/uwstrim_acc.sv
hw/rtl/uwstrim_seq.sv
hw/rtl/utf8_unicode_whitespace_trimmer.sv
tb/testbench.sv
